/* hw/rtl/xtsc_pkg.sv */
`timescale 1ns / 1ps

package xtsc_pkg;

    // Set-1 scan codes with special handling
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2a;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'haa;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hb6;
    localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
    localparam logic [7:0] SC_ALT_BREAK    = 8'hb8;
    localparam logic [7:0] SC_BREAK_BIT    = 8'h80;
    localparam logic [7:0] SC_CODE_MASK    = 8'h7f;

    localparam logic CMD_SCAN  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MAP,
        ST_SEND
    } state_t;

    function automatic logic [7:0] map_plain(input logic [6:0] code);
        logic [7:0] ch;
        ch = 8'h00;
        case (code)
            7'd1:  ch = 8'h1b;
            7'd2:  ch = 8'h31;
            7'd3:  ch = 8'h32;
            7'd4:  ch = 8'h33;
            7'd5:  ch = 8'h34;
            7'd6:  ch = 8'h35;
            7'd7:  ch = 8'h36;
            7'd8:  ch = 8'h37;
            7'd9:  ch = 8'h38;
            7'd10: ch = 8'h39;
            7'd11: ch = 8'h30;
            7'd12: ch = 8'h2d;
            7'd13: ch = 8'h2b;
            7'd14: ch = 8'h08;
            7'd15: ch = 8'h09;
            7'd16: ch = 8'h71;
            7'd17: ch = 8'h77;
            7'd18: ch = 8'h65;
            7'd19: ch = 8'h72;
            7'd20: ch = 8'h74;
            7'd21: ch = 8'h79;
            7'd22: ch = 8'h75;
            7'd23: ch = 8'h69;
            7'd24: ch = 8'h6f;
            7'd25: ch = 8'h70;
            7'd26: ch = 8'h7d;
            7'd28: ch = 8'h0a;
            7'd30: ch = 8'h61;
            7'd31: ch = 8'h73;
            7'd32: ch = 8'h64;
            7'd33: ch = 8'h66;
            7'd34: ch = 8'h67;
            7'd35: ch = 8'h68;
            7'd36: ch = 8'h6a;
            7'd37: ch = 8'h6b;
            7'd38: ch = 8'h6c;
            7'd39: ch = 8'h7c;
            7'd40: ch = 8'h7b;
            7'd43: ch = 8'h27;
            7'd44: ch = 8'h7a;
            7'd45: ch = 8'h78;
            7'd46: ch = 8'h63;
            7'd47: ch = 8'h76;
            7'd48: ch = 8'h62;
            7'd49: ch = 8'h6e;
            7'd50: ch = 8'h6d;
            7'd51: ch = 8'h3c;
            7'd55: ch = 8'h2a;
            7'd57: ch = 8'h20;
            7'd74: ch = 8'h2d;
            7'd78: ch = 8'h2b;
            7'd86: ch = 8'h3c;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] map_shift(input logic [6:0] code);
        logic [7:0] ch;
        ch = 8'h00;
        case (code)
            7'd1:  ch = 8'h1b;
            7'd2:  ch = 8'h21;
            7'd3:  ch = 8'h22;
            7'd4:  ch = 8'h23;
            7'd5:  ch = 8'h20;
            7'd6:  ch = 8'h25;
            7'd7:  ch = 8'h5e;
            7'd8:  ch = 8'h26;
            7'd9:  ch = 8'h2a;
            7'd10: ch = 8'h28;
            7'd11: ch = 8'h29;
            7'd12: ch = 8'h5f;
            7'd13: ch = 8'h3d;
            7'd14: ch = 8'h08;
            7'd15: ch = 8'h09;
            7'd16: ch = 8'h51;
            7'd17: ch = 8'h57;
            7'd18: ch = 8'h45;
            7'd19: ch = 8'h52;
            7'd20: ch = 8'h54;
            7'd21: ch = 8'h59;
            7'd22: ch = 8'h55;
            7'd23: ch = 8'h49;
            7'd24: ch = 8'h4f;
            7'd25: ch = 8'h50;
            7'd26: ch = 8'h5d;
            7'd27: ch = 8'h5e;
            7'd28: ch = 8'h0a;
            7'd30: ch = 8'h41;
            7'd31: ch = 8'h53;
            7'd32: ch = 8'h44;
            7'd33: ch = 8'h46;
            7'd34: ch = 8'h47;
            7'd35: ch = 8'h48;
            7'd36: ch = 8'h4a;
            7'd37: ch = 8'h4b;
            7'd38: ch = 8'h4c;
            7'd39: ch = 8'h3b;
            7'd40: ch = 8'h22;
            7'd43: ch = 8'h2a;
            7'd44: ch = 8'h5a;
            7'd45: ch = 8'h58;
            7'd46: ch = 8'h43;
            7'd47: ch = 8'h56;
            7'd48: ch = 8'h42;
            7'd49: ch = 8'h4e;
            7'd50: ch = 8'h4d;
            7'd51: ch = 8'h3b;
            7'd52: ch = 8'h3e;
            7'd53: ch = 8'h2f;
            7'd55: ch = 8'h2a;
            7'd57: ch = 8'h20;
            7'd74: ch = 8'h2d;
            7'd78: ch = 8'h2b;
            7'd86: ch = 8'h3e;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] map_alt(input logic [6:0] code);
        logic [7:0] ch;
        ch = 8'h00;
        case (code)
            7'd3:  ch = 8'h40;
            7'd5:  ch = 8'h24;
            7'd8:  ch = 8'h7b;
            7'd9:  ch = 8'h5b;
            7'd10: ch = 8'h5d;
            7'd11: ch = 8'h7d;
            7'd12: ch = 8'h5c;
            7'd27: ch = 8'h7e;
            7'd28: ch = 8'h0a;
            7'd86: ch = 8'h7c;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // codes above the table fall through to the default arms and give 0
    function automatic logic [7:0] decode(input logic [6:0] code, input logic shift,
                                          input logic alt);
        logic [7:0] ch;
        if (shift && alt) begin
            ch = 8'h00;
        end else if (shift) begin
            ch = map_shift(code);
        end else if (alt) begin
            ch = map_alt(code);
        end else begin
            ch = map_plain(code);
        end
        return ch;
    endfunction

endpackage

/* hw/rtl/xt_scancode_to_char_fifo_top.sv */
`timescale 1ns / 1ps

// XT set-1 scan code queue and character decoder.
// Input channel (s_): s_cmd = 0 carries one raw scan code in s_scan_code, s_cmd = 1
// asks for a drain. Shift and alt make/break codes update the modifier flags, other
// break codes are dropped, and remaining codes are queued (low 7 bits) while there is
// room; a code that arrives on a full queue is dropped.
// Result channel (m_): a drain yields one m_char_code per queued code, oldest first,
// mapped through the plain, shift or alt table picked by the flags, or 0 with both set;
// m_last marks the final character. A drain of an empty queue yields nothing.
// Drain order: each code passes through a queue memory read, a table lookup into the
// output register and the result transfer, which waits while the receiver holds
// m_ready low.
// s_ready is high only when no drain is in progress.
// Stall: the result register holds its value until the receiver takes it.
// Reset (aresetn low, synchronous): queue emptied, pointers and flags cleared,
// no result pending. Queue contents are not cleared.
module xt_scancode_to_char_fifo_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [7:0] s_scan_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_char_code,
    output logic       m_last
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    xtsc_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             shift_reg, shift_next;
    logic             alt_reg, alt_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;

    logic [6:0]       queue_mem [QUEUE_DEPTH];
    logic [6:0]       rd_data_reg;
    logic             wr_en;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            queue_mem[wr_ptr_reg] <= s_scan_code[6:0] & xtsc_pkg::SC_CODE_MASK[6:0];
        end
        rd_data_reg <= queue_mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= xtsc_pkg::ST_IDLE;
            count_reg   <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            shift_reg   <= 1'b0;
            alt_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            shift_reg   <= shift_next;
            alt_reg     <= alt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        shift_next   = shift_reg;
        alt_next     = alt_reg;
        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        wr_en        = 1'b0;
        s_ready      = 1'b0;

        case (state_reg)
            xtsc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_cmd == xtsc_pkg::CMD_DRAIN) begin
                        if (count_reg != '0) begin
                            state_next = xtsc_pkg::ST_FETCH;
                        end
                    end else if (s_scan_code == xtsc_pkg::SC_LSHIFT_MAKE ||
                                 s_scan_code == xtsc_pkg::SC_RSHIFT_MAKE) begin
                        shift_next = 1'b1;
                    end else if (s_scan_code == xtsc_pkg::SC_LSHIFT_BREAK ||
                                 s_scan_code == xtsc_pkg::SC_RSHIFT_BREAK) begin
                        shift_next = 1'b0;
                    end else if (s_scan_code == xtsc_pkg::SC_ALT_MAKE) begin
                        alt_next = 1'b1;
                    end else if (s_scan_code == xtsc_pkg::SC_ALT_BREAK) begin
                        alt_next = 1'b0;
                    end else if ((s_scan_code & xtsc_pkg::SC_BREAK_BIT) == 8'h00 &&
                                 count_reg != CNT_FULL) begin
                        wr_en       = 1'b1;
                        wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                end
            end
            xtsc_pkg::ST_FETCH: begin
                // memory read of the head entry lands in rd_data_reg
                state_next = xtsc_pkg::ST_MAP;
            end
            xtsc_pkg::ST_MAP: begin
                char_next    = xtsc_pkg::decode(rd_data_reg, shift_reg, alt_reg);
                last_next    = (count_reg == CNT_ONE);
                m_valid_next = 1'b1;
                rd_ptr_next  = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
                count_next   = count_reg - 1'b1;
                state_next   = xtsc_pkg::ST_SEND;
            end
            xtsc_pkg::ST_SEND: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = (count_reg == '0) ? xtsc_pkg::ST_IDLE : xtsc_pkg::ST_FETCH;
                end
            end
            default: begin
                state_next = xtsc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_char_code = char_reg;
    assign m_last      = last_reg;

endmodule

/* hw/rtl/xtsc_checker.sv */
`timescale 1ns / 1ps

module xtsc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_cmd,
    input logic [7:0] s_scan_code,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_char_code,
    input logic       m_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_char_code) && $stable(m_last))
        else $error("result changed while stalled");

    // no new input is taken while a drain result is pending
    a_busy_when_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while result pending");

    // a scan code transfer produces no result
    a_scan_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd == xtsc_pkg::CMD_SCAN |=> !m_valid)
        else $error("result after scan code transfer");

    // drain continues after a non-final character
    a_drain_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> !s_ready)
        else $error("drain ended before last character");

    // the byte of a scan transfer is only meaningful with valid
    a_scan_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd == xtsc_pkg::CMD_SCAN |-> !$isunknown(s_scan_code))
        else $error("unknown scan code transferred");

endmodule

bind xt_scancode_to_char_fifo_top xtsc_checker u_xtsc_checker (.*);

/* test/tb_xt_scancode_to_char_fifo_top.sv */
`timescale 1ns / 1ps

module tb_xt_scancode_to_char_fifo_top;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAP_LEN = 97;
    localparam int RESULT_HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 70;
    localparam int CLOSING_ITEMS = 24;
    localparam int DRAIN_WAIT_LIMIT = 20000;
    // retired alt release code, treated as an ordinary break code
    localparam logic [7:0] SC_OLD_ALT_BREAK = 8'ha6;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_exp_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_cmd;
    logic [7:0] s_scan_code;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_char_code;
    logic       m_last;

    xt_scancode_to_char_fifo_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_scan_code(s_scan_code),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_char_code(m_char_code),
        .m_last     (m_last)
    );

    // character maps, indexed by the 7-bit key code
    logic [7:0] plain_map [0:MAP_LEN-1] = '{
        8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h2b, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6f, 8'h70, 8'h7d, 8'h00, 8'h0a, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h7c,
        8'h7b, 8'h00, 8'h00, 8'h27, 8'h7a, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6e, 8'h6d, 8'h3c, 8'h00, 8'h00, 8'h00, 8'h2a,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h2d, 8'h00, 8'h00, 8'h00, 8'h2b, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3c, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00
    };

    logic [7:0] shift_map [0:MAP_LEN-1] = '{
        8'h00, 8'h1b, 8'h21, 8'h22, 8'h23, 8'h20, 8'h25, 8'h5e,
        8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h3d, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'h5d, 8'h5e, 8'h0a, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
        8'h22, 8'h00, 8'h00, 8'h2a, 8'h5a, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h4d, 8'h3b, 8'h3e, 8'h2f, 8'h00, 8'h2a,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h2d, 8'h00, 8'h00, 8'h00, 8'h2b, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3e, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00
    };

    logic [7:0] alt_map [0:MAP_LEN-1] = '{
        8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h24, 8'h00, 8'h00,
        8'h7b, 8'h5b, 8'h5d, 8'h7d, 8'h5c, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h7e, 8'h0a, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7c, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00
    };

    // predicted keyboard state
    logic [6:0]  key_queue [$];
    logic        shift_down;
    logic        alt_down;
    char_exp_t   expected_chars [$];
    char_exp_t   head_char;

    logic        gap_en;
    logic        stall_en;
    logic        hold_req;

    int unsigned err_count;
    int unsigned items_sent;
    int unsigned live_items;
    int unsigned drain_count;
    int unsigned chars_checked;
    int unsigned full_drops;
    int unsigned both_mod_chars;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("xt_scancode_to_char_fifo_top verification failed");
        $finish;
    end

    function automatic logic [7:0] lookup_char(input logic [6:0] code);
        if (shift_down && alt_down)
            return 8'h00;
        if (code >= MAP_LEN)
            return 8'h00;
        if (shift_down)
            return shift_map[code];
        if (alt_down)
            return alt_map[code];
        return plain_map[code];
    endfunction

    // updates the predicted state for one accepted transfer
    function automatic void apply_item(input logic cmd, input logic [7:0] sc);
        logic [6:0] code;
        char_exp_t  ce;
        items_sent++;
        if (cmd == xtsc_pkg::CMD_SCAN) begin
            if (sc == xtsc_pkg::SC_LSHIFT_MAKE || sc == xtsc_pkg::SC_RSHIFT_MAKE) begin
                shift_down = 1'b1;
            end else if (sc == xtsc_pkg::SC_LSHIFT_BREAK ||
                         sc == xtsc_pkg::SC_RSHIFT_BREAK) begin
                shift_down = 1'b0;
            end else if (sc == xtsc_pkg::SC_ALT_MAKE) begin
                alt_down = 1'b1;
            end else if (sc == xtsc_pkg::SC_ALT_BREAK) begin
                alt_down = 1'b0;
            end else if ((sc & xtsc_pkg::SC_BREAK_BIT) != 8'h00) begin
                return;
            end else if (key_queue.size() >= QUEUE_DEPTH) begin
                full_drops++;
            end else begin
                key_queue.push_back(sc[6:0] & xtsc_pkg::SC_CODE_MASK[6:0]);
            end
            live_items++;
        end else begin
            drain_count++;
            live_items++;
            while (key_queue.size() > 0) begin
                code = key_queue.pop_front();
                ce.ch = lookup_char(code);
                ce.last = (key_queue.size() == 0);
                if (shift_down && alt_down)
                    both_mod_chars++;
                expected_chars.push_back(ce);
            end
        end
    endfunction

    // call only right after a rising edge; leaves s_valid high
    task automatic send_item(input logic cmd, input logic [7:0] sc);
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_scan_code <= sc;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        apply_item(cmd, sc);
    endtask

    task automatic sender_pause();
        if (gap_en && $urandom_range(3, 0) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge aclk);
        end
    endtask

    task automatic send_scan(input logic [7:0] sc);
        send_item(xtsc_pkg::CMD_SCAN, sc);
        sender_pause();
    endtask

    task automatic send_drain();
        send_item(xtsc_pkg::CMD_DRAIN, 8'($urandom));
        sender_pause();
    endtask

    function automatic logic [7:0] random_scan_code();
        int unsigned roll;
        logic [7:0]  pick;
        roll = $urandom_range(99, 0);
        if (roll < 70) begin
            pick = 8'($urandom_range(127, 0));
        end else if (roll < 80) begin
            pick = 8'($urandom);
        end else if (roll < 88) begin
            pick = xtsc_pkg::SC_BREAK_BIT | 8'($urandom_range(127, 0));
        end else begin
            case ($urandom_range(6, 0))
                0: pick = xtsc_pkg::SC_LSHIFT_MAKE;
                1: pick = xtsc_pkg::SC_RSHIFT_MAKE;
                2: pick = xtsc_pkg::SC_LSHIFT_BREAK;
                3: pick = xtsc_pkg::SC_RSHIFT_BREAK;
                4: pick = xtsc_pkg::SC_ALT_MAKE;
                5: pick = xtsc_pkg::SC_ALT_BREAK;
                default: pick = SC_OLD_ALT_BREAK;
            endcase
        end
        return pick;
    endfunction

    task automatic test_empty_drain();
        send_drain();
    endtask

    // plain map, codes past the map end, break codes mixed in
    task automatic test_plain_and_breaks();
        send_scan(8'h00);
        send_scan(8'h9e);
        send_scan(8'h1e);
        send_scan(SC_OLD_ALT_BREAK);
        send_scan(8'h56);
        send_scan(8'hff);
        send_scan(8'h61);
        send_scan(8'h7f);
        send_item(xtsc_pkg::CMD_DRAIN, 8'h80);
        sender_pause();
    endtask

    // map is picked by the flags at drain time; here shift is held at queue and drain time
    task automatic test_shift_map();
        send_scan(xtsc_pkg::SC_LSHIFT_MAKE);
        send_scan(8'h02);
        send_scan(xtsc_pkg::SC_LSHIFT_BREAK);
        send_scan(xtsc_pkg::SC_RSHIFT_MAKE);
        send_scan(8'h35);
        send_drain();
        send_scan(xtsc_pkg::SC_RSHIFT_BREAK);
    endtask

    task automatic test_alt_map();
        send_scan(xtsc_pkg::SC_ALT_MAKE);
        send_scan(8'h0c);
        send_scan(8'h56);
        send_drain();
        send_scan(xtsc_pkg::SC_ALT_BREAK);
    endtask

    task automatic test_both_modifiers();
        send_scan(xtsc_pkg::SC_RSHIFT_MAKE);
        send_scan(xtsc_pkg::SC_ALT_MAKE);
        send_scan(8'h1e);
        send_drain();
        send_scan(xtsc_pkg::SC_LSHIFT_BREAK);
        send_scan(xtsc_pkg::SC_ALT_BREAK);
    endtask

    // overfill the queue, then hold the result side while more codes wait
    task automatic test_full_queue_stall();
        int i;
        for (i = 0; i < QUEUE_DEPTH + 4; i++)
            send_scan(8'($urandom_range(96, 1)));
        hold_req = 1'b1;
        send_drain();
        for (i = 0; i < 6; i++)
            send_scan(8'($urandom_range(127, 0)));
        send_drain();
    endtask

    // well-formed typing bursts ending in a drain, with noise mixed in
    task automatic test_random_typing(input int unsigned target);
        int unsigned stop_at;
        int unsigned n;
        int unsigned k;
        stop_at = live_items + target;
        while (live_items < stop_at) begin
            if ($urandom_range(2, 0) == 0)
                send_scan($urandom_range(1, 0) ? xtsc_pkg::SC_LSHIFT_MAKE :
                                                 xtsc_pkg::SC_RSHIFT_MAKE);
            if ($urandom_range(3, 0) == 0)
                send_scan(xtsc_pkg::SC_ALT_MAKE);
            n = ($urandom_range(7, 0) == 0) ? $urandom_range(22, 14) : $urandom_range(8, 0);
            for (k = 0; k < n; k++)
                send_scan(random_scan_code());
            send_drain();
            if ($urandom_range(1, 0) == 0)
                send_scan($urandom_range(1, 0) ? xtsc_pkg::SC_LSHIFT_BREAK :
                                                 xtsc_pkg::SC_RSHIFT_BREAK);
            if ($urandom_range(1, 0) == 0)
                send_scan(xtsc_pkg::SC_ALT_BREAK);
        end
    endtask

    // result side
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (RESULT_HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (stall_en && $urandom_range(4, 0) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(7, 0)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected char transfer, expected none, got 0x%02h last=%0b",
                         $time, m_char_code, m_last);
                err_count++;
            end else begin
                head_char = expected_chars.pop_front();
                chars_checked++;
                if (m_char_code !== head_char.ch) begin
                    $display("%0t: char_code mismatch, expected 0x%02h, got 0x%02h",
                             $time, head_char.ch, m_char_code);
                    err_count++;
                end
                if (m_last !== head_char.last) begin
                    $display("%0t: last mismatch, expected %0b, got %0b",
                             $time, head_char.last, m_last);
                    err_count++;
                end
            end
        end
    end

    initial begin
        int unsigned waited;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = xtsc_pkg::CMD_SCAN;
        s_scan_code = 8'h00;
        shift_down = 1'b0;
        alt_down = 1'b0;
        gap_en = 1'b1;
        stall_en = 1'b1;
        hold_req = 1'b0;
        err_count = 0;
        items_sent = 0;
        live_items = 0;
        drain_count = 0;
        chars_checked = 0;
        full_drops = 0;
        both_mod_chars = 0;
        waited = 0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_drain();
        test_plain_and_breaks();
        test_shift_map();
        test_alt_map();
        test_both_modifiers();
        test_full_queue_stall();
        test_random_typing(RANDOM_ITEMS);
        gap_en = 1'b0;
        stall_en = 1'b0;
        test_random_typing(CLOSING_ITEMS);
        s_valid <= 1'b0;

        while (expected_chars.size() != 0 && waited < DRAIN_WAIT_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (waited >= DRAIN_WAIT_LIMIT) begin
            $display("xt_scancode_to_char_fifo_top verification failed");
        end else begin
            repeat (12) @(posedge aclk);
            $display("Sent %0d transfers (%0d drains), checked %0d characters.",
                     items_sent, drain_count, chars_checked);
            $display("Codes dropped on a full queue: %0d, chars with shift+alt held: %0d.",
                     full_drops, both_mod_chars);
            if (err_count == 0 && expected_chars.size() == 0) begin
                $display("xt_scancode_to_char_fifo_top verification clean");
            end else begin
                $display("xt_scancode_to_char_fifo_top verification failed");
            end
        end
        $finish;
    end

endmodule
